/* sv/bdq_pkg.sv */
// Package for the bounded deque: request and status codes, cell command struct.
// No dependencies; used by bdq_cell and bounded_deque_unit.
package bdq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int WORD_W = 32;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_REAR = 2'd1,
		FN_POP_FRONT = 2'd2,
		FN_POP_REAR = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Commands broadcast to every cell of the chain; at most one is set per cycle.
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} cell_cmd_t;

endpackage

/* sv/bdq_cell.sv */
// One storage cell of the deque chain: a word, its valid bit and a return stage.
// Depends on bdq_pkg for the word width and the cell command struct.
module bdq_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bdq_pkg::cell_cmd_t             cmd,
	input  logic [bdq_pkg::WORD_W-1:0]     push_data,
	input  logic [bdq_pkg::WORD_W-1:0]     left_word,
	input  logic                           left_valid,
	input  logic [bdq_pkg::WORD_W-1:0]     right_word,
	input  logic                           right_valid,
	input  logic [bdq_pkg::WORD_W-1:0]     ret_in,
	output logic [bdq_pkg::WORD_W-1:0]     word,
	output logic                           valid,
	output logic [bdq_pkg::WORD_W-1:0]     ret
);

	logic [bdq_pkg::WORD_W-1:0] word_q;
	logic [bdq_pkg::WORD_W-1:0] ret_q;
	logic                       valid_q;
	logic                       is_last;
	logic                       take_rear;

	assign is_last = valid_q && !right_valid;
	assign take_rear = cmd.push_rear && !valid_q && left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push_front) begin
			valid_q <= left_valid;
		end else if (cmd.pop_front) begin
			valid_q <= right_valid;
		end else if (take_rear) begin
			valid_q <= 1'b1;
		end else if (cmd.pop_rear && is_last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			word_q <= left_word;
		end else if (cmd.pop_front) begin
			word_q <= right_word;
		end else if (take_rear) begin
			word_q <= push_data;
		end
	end

	// The word removed from the rear travels toward cell zero, one cell a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= '0;
		end else if (cmd.pop_rear && is_last) begin
			ret_q <= word_q;
		end else begin
			ret_q <= ret_in;
		end
	end

	assign word = word_q;
	assign valid = valid_q;
	assign ret = ret_q;

endmodule

/* sv/bounded_deque_unit.sv */
// Top level of the bounded deque: control, result registers and the chain of cells.
// Depends on bdq_pkg and instantiates bdq_cell once per entry.
//
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    func, data
// result    out        done high for one cycle status, popped_value, item_count
//
// Push front, push rear, pop front and every refused request give their result
// in the cycle after acceptance.
// A successful pop rear holds the unit in the chase state while the rear word walks
// down the cell chain to cell zero; the result is shown once it has arrived.
// Reset empties the deque; stored words are not cleared.
// The receiver cannot stall; busy is high only while a rear word is in flight.
module bounded_deque_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [bdq_pkg::FUNC_W-1:0]           func,
	input  logic signed [bdq_pkg::WORD_W-1:0]    data,
	output logic                                 done,
	output logic [bdq_pkg::STATUS_W-1:0]         status,
	output logic signed [bdq_pkg::WORD_W-1:0]    popped_value,
	output logic [bdq_pkg::COUNT_OUT_W-1:0]      item_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CHASE = 2'b10
	} state_t;

	state_t                              state_q;
	logic [CW-1:0]                       count_q;
	logic [IW-1:0]                       wait_q;
	logic                                done_q;
	logic [bdq_pkg::STATUS_W-1:0]        status_q;
	logic [bdq_pkg::WORD_W-1:0]          value_q;
	logic [bdq_pkg::COUNT_OUT_W-1:0]     item_count_q;

	logic                                accept;
	logic                                full;
	logic                                empty;
	bdq_pkg::cell_cmd_t                  cmd;

	logic [bdq_pkg::WORD_W-1:0]          word_w [DEPTH];
	logic [bdq_pkg::WORD_W-1:0]          ret_w [DEPTH];
	logic [DEPTH-1:0]                    valid_w;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd = '0;
		if (accept) begin
			case (bdq_pkg::func_t'(func))
				bdq_pkg::FN_PUSH_FRONT: cmd.push_front = !full;
				bdq_pkg::FN_PUSH_REAR: cmd.push_rear = !full;
				bdq_pkg::FN_POP_FRONT: cmd.pop_front = !empty;
				bdq_pkg::FN_POP_REAR: cmd.pop_rear = !empty;
				default: cmd = '0;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [bdq_pkg::WORD_W-1:0] left_word;
		logic                       left_valid;
		logic [bdq_pkg::WORD_W-1:0] right_word;
		logic                       right_valid;
		logic [bdq_pkg::WORD_W-1:0] ret_in;

		if (i == 0) begin : g_first
			assign left_word = data;
			assign left_valid = 1'b1;
		end else begin : g_inner_left
			assign left_word = word_w[i-1];
			assign left_valid = valid_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = '0;
			assign right_valid = 1'b0;
			assign ret_in = '0;
		end else begin : g_inner_right
			assign right_word = word_w[i+1];
			assign right_valid = valid_w[i+1];
			assign ret_in = ret_w[i+1];
		end

		bdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.push_data   (data),
			.left_word   (left_word),
			.left_valid  (left_valid),
			.right_word  (right_word),
			.right_valid (right_valid),
			.ret_in      (ret_in),
			.word        (word_w[i]),
			.valid       (valid_w[i]),
			.ret         (ret_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wait_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.push_front || cmd.push_rear) begin
							count_q <= count_q + CW'(1);
							done_q <= 1'b1;
						end else if (cmd.pop_front) begin
							count_q <= count_q - CW'(1);
							done_q <= 1'b1;
						end else if (cmd.pop_rear) begin
							count_q <= count_q - CW'(1);
							wait_q <= IW'(count_q - CW'(1));
							state_q <= S_CHASE;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_CHASE: begin
					if (wait_q == '0) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wait_q <= wait_q - IW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHASE) begin
			status_q <= bdq_pkg::ST_OK;
			value_q <= ret_w[0];
			item_count_q <= bdq_pkg::COUNT_OUT_W'(count_q);
		end else if (accept) begin
			value_q <= '0;
			if (bdq_pkg::func_t'(func) == bdq_pkg::FN_PUSH_FRONT ||
			    bdq_pkg::func_t'(func) == bdq_pkg::FN_PUSH_REAR) begin
				status_q <= full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
				item_count_q <= bdq_pkg::COUNT_OUT_W'(full ? count_q : count_q + CW'(1));
			end else begin
				status_q <= empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
				item_count_q <= bdq_pkg::COUNT_OUT_W'(empty ? count_q : count_q - CW'(1));
				if (cmd.pop_front) begin
					value_q <= word_w[0];
				end
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign popped_value = value_q;
	assign item_count = item_count_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Stored count exceeds the capacity.");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("Cell valid bits disagree with the stored count.");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_w + DEPTH'(1)) & valid_w) == '0)
		else $error("Occupied cells are not packed from cell zero.");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd.pop_rear) |=> done_q)
		else $error("A one-cycle request gave no result in the next cycle.");

	a_chase_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rear |=> (busy && !done_q))
		else $error("A rear pop did not hold the unit busy.");

	a_chase_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && $past(state_q == S_CHASE)) |-> (status_q == bdq_pkg::ST_OK))
		else $error("A rear pop finished with a refusal status.");
`endif

endmodule

/* bench/tb_bounded_deque_unit.sv */
// Self-checking testbench for bounded_deque_unit: directed and random push and pop requests.
// A behavioral deque predicts every result, which is compared field by field.
// Depends on bdq_pkg and bounded_deque_unit.
module tb_bounded_deque_unit;

	localparam int CAP = bdq_pkg::DEPTH_DEF;
	localparam int HALF = 10;
	localparam int RANDOM_REQUESTS = 1700;

	typedef struct {
		bdq_pkg::func_t fn;
		logic signed [bdq_pkg::WORD_W-1:0] word;
		int unsigned gap;
		bit drain;
	} request_t;

	typedef struct {
		bdq_pkg::status_t st;
		logic signed [bdq_pkg::WORD_W-1:0] val;
		logic [bdq_pkg::COUNT_OUT_W-1:0] cnt;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [bdq_pkg::FUNC_W-1:0] func;
	logic signed [bdq_pkg::WORD_W-1:0] data;
	logic done;
	logic [bdq_pkg::STATUS_W-1:0] status;
	logic signed [bdq_pkg::WORD_W-1:0] popped_value;
	logic [bdq_pkg::COUNT_OUT_W-1:0] item_count;

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];

	logic signed [bdq_pkg::WORD_W-1:0] model_words [CAP];
	int unsigned model_head;
	int unsigned model_count;
	int unsigned errors;
	int unsigned n_ok;
	int unsigned n_full;
	int unsigned n_empty;
	int unsigned gap_count;
	bit req_taken;

	bounded_deque_unit #(
		.DEPTH(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.data(data),
		.done(done),
		.status(status),
		.popped_value(popped_value),
		.item_count(item_count)
	);

	initial clk = 1'b0;
	always #HALF clk = ~clk;

	function automatic outcome_t deque_apply(bdq_pkg::func_t fn,
			logic signed [bdq_pkg::WORD_W-1:0] word);
		outcome_t o;
		o.st = bdq_pkg::ST_OK;
		o.val = '0;
		case (fn)
			bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_REAR: begin
				if (model_count == CAP) begin
					o.st = bdq_pkg::ST_FULL;
				end else if (fn == bdq_pkg::FN_PUSH_FRONT) begin
					model_head = (model_head + CAP - 1) % CAP;
					model_words[model_head] = word;
					model_count++;
				end else begin
					model_words[(model_head + model_count) % CAP] = word;
					model_count++;
				end
			end
			bdq_pkg::FN_POP_FRONT: begin
				if (model_count == 0) begin
					o.st = bdq_pkg::ST_EMPTY;
				end else begin
					o.val = model_words[model_head];
					model_head = (model_head + 1) % CAP;
					model_count--;
				end
			end
			default: begin
				if (model_count == 0) begin
					o.st = bdq_pkg::ST_EMPTY;
				end else begin
					o.val = model_words[(model_head + model_count - 1) % CAP];
					model_count--;
				end
			end
		endcase
		o.cnt = bdq_pkg::COUNT_OUT_W'(model_count);
		return o;
	endfunction

	task automatic check_field(string what, logic signed [bdq_pkg::WORD_W-1:0] exp_v,
			logic signed [bdq_pkg::WORD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic add_request(bdq_pkg::func_t fn, logic signed [bdq_pkg::WORD_W-1:0] word,
			int unsigned gap, bit drain);
		request_t r;
		r.fn = fn;
		r.word = word;
		r.gap = gap;
		r.drain = drain;
		pending_requests.push_back(r);
	endtask

	always @(posedge clk) begin : monitor
		outcome_t e;
		if (arst_n) begin
			req_taken <= start && !busy;
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result with no request waiting, status %0d value %0d count %0d",
						$time, status, popped_value, item_count);
					errors++;
				end else begin
					e = expected_outcomes.pop_front();
					check_field("status", e.st, status);
					check_field("popped_value", e.val, popped_value);
					check_field("item_count", e.cnt, item_count);
					case (e.st)
						bdq_pkg::ST_OK: n_ok++;
						bdq_pkg::ST_FULL: n_full++;
						default: n_empty++;
					endcase
				end
			end
			if (start && !busy) begin
				expected_outcomes.push_back(deque_apply(bdq_pkg::func_t'(func), data));
			end
		end
	end

	always @(negedge clk) begin : driver
		request_t r;
		if (arst_n && !(start && !req_taken)) begin
			if (pending_requests.size() == 0) begin
				start <= 1'b0;
			end else if (gap_count < pending_requests[0].gap ||
					(pending_requests[0].drain && expected_outcomes.size() != 0)) begin
				start <= 1'b0;
				if (gap_count < pending_requests[0].gap) begin
					gap_count++;
				end
			end else begin
				r = pending_requests.pop_front();
				start <= 1'b1;
				func <= r.fn;
				data <= r.word;
				gap_count = 0;
			end
		end
	end

	initial begin : stimulus
		int unsigned total;
		int unsigned seg_len;
		int unsigned push_pct;
		bit no_idle;
		bit drain_first;
		bdq_pkg::func_t fn;
		logic signed [bdq_pkg::WORD_W-1:0] word;
		arst_n = 1'b0;
		start = 1'b0;
		func = bdq_pkg::FN_PUSH_FRONT;
		data = '0;
		req_taken = 1'b0;
		gap_count = 0;
		model_head = 0;
		model_count = 0;
		errors = 0;
		n_ok = 0;
		n_full = 0;
		n_empty = 0;
		foreach (model_words[i]) model_words[i] = '0;

		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_PUSH_FRONT, 32'sh7fffffff, 0, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, 32'sh80000000, 0, 0);
		add_request(bdq_pkg::FN_PUSH_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, -32'sd1, 0, 0);
		add_request(bdq_pkg::FN_PUSH_FRONT, 32'sh55555555, 3, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, 32'shaaaaaaaa, 0, 0);
		add_request(bdq_pkg::FN_PUSH_FRONT, 32'sd1, 0, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, 32'sh12345678, 0, 0);
		add_request(bdq_pkg::FN_PUSH_FRONT, 32'sh0badcafe, 0, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, 32'sh7fffffff, 0, 1);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 2, 0);
		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_POP_REAR, 32'sd0, 0, 0);
		add_request(bdq_pkg::FN_PUSH_REAR, 32'sh80000000, 0, 0);
		add_request(bdq_pkg::FN_POP_FRONT, 32'sd0, 0, 0);

		total = 0;
		while (total < RANDOM_REQUESTS) begin
			seg_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 20;
				1: push_pct = 50;
				default: push_pct = 80;
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			drain_first = ($urandom_range(0, 5) == 0);
			for (int unsigned k = 0; k < seg_len; k++) begin
				if ($urandom_range(0, 99) < push_pct) begin
					fn = $urandom_range(0, 1) ? bdq_pkg::FN_PUSH_REAR : bdq_pkg::FN_PUSH_FRONT;
				end else begin
					fn = $urandom_range(0, 1) ? bdq_pkg::FN_POP_REAR : bdq_pkg::FN_POP_FRONT;
				end
				case ($urandom_range(0, 11))
					0: word = 32'sh80000000;
					1: word = 32'sh7fffffff;
					2: word = 32'sd0;
					3: word = -32'sd1;
					default: word = $urandom;
				endcase
				add_request(fn, word, no_idle ? 0 : $urandom_range(0, 14),
					drain_first && k == 0);
			end
			total += seg_len;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (2 * CAP + 4) @(posedge clk);

		$display("Checked %0d results of directed and random requests with idle gaps and drains.",
			n_ok + n_full + n_empty);
		$display("%0d served, %0d pushes refused as full, %0d pops refused as empty.",
			n_ok, n_full, n_empty);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(2 * HALF * 400000);
		$display("Timeout: requests still pending or results missing.");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
